[hdl/cshl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cshl_pkg;

    localparam int LOOKAHEAD_DEF     = 9;
    localparam int KEYWORD_COUNT_DEF = 23;
    localparam int KW_TABLE_SIZE     = 23;
    localparam int KW_MAX_LEN        = 8;

    typedef enum logic [2:0] {
        CLS_NORMAL,
        CLS_LINE_COMMENT,
        CLS_BLOCK_COMMENT,
        CLS_KEYWORD,
        CLS_TYPE,
        CLS_STRING,
        CLS_NUMBER
    } t_hl_class;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNTAX  = 2'd0;
    localparam logic [1:0] CFG_NUMBERS = 2'd1;
    localparam logic [1:0] CFG_STRINGS = 2'd2;

    // open string quote codes
    localparam logic [1:0] Q_NONE   = 2'd0;
    localparam logic [1:0] Q_DOUBLE = 2'd1;
    localparam logic [1:0] Q_SINGLE = 2'd2;

    typedef struct packed {
        t_hl_class cls;
        logic      line_last;
        logic      open_comment;
        logic      last_of_run;
    } t_res;

    function automatic logic [63:0] kw_text(input int j);
        logic [63:0] s;
        case (j)
            0:       s = "switch";
            1:       s = "if";
            2:       s = "while";
            3:       s = "for";
            4:       s = "break";
            5:       s = "continue";
            6:       s = "return";
            7:       s = "else";
            8:       s = "struct";
            9:       s = "union";
            10:      s = "typedef";
            11:      s = "static";
            12:      s = "enum";
            13:      s = "class";
            14:      s = "case";
            15:      s = "int";
            16:      s = "long";
            17:      s = "double";
            18:      s = "float";
            19:      s = "char";
            20:      s = "unsigned";
            21:      s = "signed";
            default: s = "void";
        endcase
        return s;
    endfunction

    function automatic int kw_len(input int j);
        int l;
        case (j)
            1:                  l = 2;
            3, 15:              l = 3;
            7, 12, 14, 16, 19:  l = 4;
            2, 4, 9, 13, 18:    l = 5;
            10:                 l = 7;
            5, 20:              l = 8;
            22:                 l = 4;
            default:            l = 6;
        endcase
        return l;
    endfunction

    function automatic t_hl_class kw_cls(input int j);
        return (j >= 15) ? CLS_TYPE : CLS_KEYWORD;
    endfunction

    // byte t of keyword j, first character at t = 0
    function automatic logic [7:0] kw_char(input int j, input int t);
        logic [63:0] s;
        int          l;
        s = kw_text(j);
        l = kw_len(j);
        return s[8*(l-1-t) +: 8];
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == 8'd0) || (c == " ") || (c >= 8'd9 && c <= 8'd13) ||
               (c == ",") || (c == ".") || (c == "(") || (c == ")") ||
               (c == "+") || (c == "-") || (c == "/") || (c == "*") ||
               (c == "=") || (c == "~") || (c == "%") || (c == "<") ||
               (c == ">") || (c == "[") || (c == "]") || (c == ";");
    endfunction

endpackage
`default_nettype wire

[hdl/c_syntax_highlight_lexer.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel  direction  handshake            payload
// input    in         i_valid / o_stall    i_char_byte, i_line_end, i_first_of_file
// result   out        o_valid / i_stall    o_highlight_class, o_line_last,
//                                          o_open_comment, o_last_of_run
// config   in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One byte per cycle; a byte that fills the window yields one result in the same
// cycle (registered in a two-entry output queue).
// A line end flushes the window: input stalls while the
// held bytes drain one per cycle, paced by the output queue.
// Synchronous active-low reset clears control and line state; config resets to 1.
// Input stalls whenever the output queue is full or a flush is running.
module c_syntax_highlight_lexer
    import cshl_pkg::*;
#(
    parameter int LOOKAHEAD     = LOOKAHEAD_DEF,
    parameter int KEYWORD_COUNT = KEYWORD_COUNT_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_byte,
    input  wire logic       i_line_end,
    input  wire logic       i_first_of_file,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [2:0]      o_highlight_class,
    output logic            o_line_last,
    output logic            o_open_comment,
    output logic            o_last_of_run,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic       i_cfg_data
);

    localparam int CW      = $clog2(LOOKAHEAD + 1);
    localparam int IW      = $clog2(LOOKAHEAD);
    localparam int KW_USED = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT : KW_TABLE_SIZE;

    // window and line state
    logic [7:0] r_win [LOOKAHEAD];
    t_hl_class  r_lab [LOOKAHEAD];
    logic [CW-1:0] r_fill, r_ahead;
    logic       r_blk, r_esc, r_sep, r_rest, r_flush;
    logic [1:0] r_q;
    t_hl_class  r_prev;
    logic       r_syn, r_num, r_str;

    // after the push
    logic [7:0] a_win [LOOKAHEAD];
    t_hl_class  a_lab [LOOKAHEAD];
    logic [CW-1:0] a_fill, a_ahead;
    logic       a_blk, a_esc, a_sep, a_rest;
    logic [1:0] a_q;
    t_hl_class  a_prev;

    // after decide and shift
    t_hl_class  n_lab [LOOKAHEAD];
    logic [CW-1:0] n_fill, n_ahead;
    logic       n_blk, n_esc, n_sep, n_rest, n_flush;
    logic [1:0] n_q;
    t_hl_class  n_prev;

    logic [7:0] w_peek [KW_MAX_LEN+1];
    logic       w_accept, w_emit, w_last;
    t_res       w_res;

    // output queue
    t_res       r_fq [2];
    logic       r_fhead;
    logic [1:0] r_fcnt;
    logic       w_pop;

    assign o_stall     = r_flush || (r_fcnt == 2'd2);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !o_stall;
    assign w_pop       = o_valid && !i_stall;

    // push stage
    always_comb begin
        a_win   = r_win;
        a_lab   = r_lab;
        a_fill  = r_fill;
        a_ahead = r_ahead;
        a_blk   = r_blk;
        a_q     = r_q;
        a_esc   = r_esc;
        a_sep   = r_sep;
        a_prev  = r_prev;
        a_rest  = r_rest;
        if (w_accept) begin
            if (i_first_of_file) begin
                a_q = Q_NONE; a_esc = 1'b0; a_sep = 1'b1; a_prev = CLS_NORMAL;
                a_rest = 1'b0; a_ahead = '0; a_fill = '0; a_blk = 1'b0;
            end
            a_win[a_fill[IW-1:0]] = i_char_byte;
            a_lab[a_fill[IW-1:0]] = a_rest ? CLS_LINE_COMMENT : CLS_NORMAL;
            a_fill = a_fill + 1'b1;
            if (a_rest) begin
                a_ahead = a_fill;
            end
        end
    end

    // bytes past the fill or the window read as NUL
    for (genvar g = 0; g <= KW_MAX_LEN; g++) begin : g_peek
        if (g < LOOKAHEAD) begin : g_in
            assign w_peek[g] = (CW'(g) < a_fill) ? a_win[g] : 8'd0;
        end else begin : g_out
            assign w_peek[g] = 8'd0;
        end
    end

    assign w_emit = (w_accept && !i_line_end && (a_fill == CW'(LOOKAHEAD))) ||
                    (r_flush && (r_fcnt != 2'd2));
    assign w_last = r_flush && (a_fill == CW'(1));

    // decide the head byte, then shift it out
    always_comb begin
        logic [KW_TABLE_SIZE-1:0] hit;
        logic      b0_dig;
        logic [7:0] b0, b1;
        int        sel;
        int        sel_len;
        t_hl_class sel_cls;
        n_lab   = a_lab;
        n_fill  = a_fill;
        n_ahead = a_ahead;
        n_blk   = a_blk;
        n_q     = a_q;
        n_esc   = a_esc;
        n_sep   = a_sep;
        n_prev  = a_prev;
        n_rest  = a_rest;
        b0      = w_peek[0];
        b1      = w_peek[1];
        b0_dig  = (b0 >= "0") && (b0 <= "9");
        hit     = '0;
        for (int j = 0; j < KW_TABLE_SIZE; j++) begin
            hit[j] = (j < KW_USED) && is_sep(w_peek[kw_len(j)]);
            for (int t = 0; t < KW_MAX_LEN; t++) begin
                if (t < kw_len(j) && w_peek[t] != kw_char(j, t)) begin
                    hit[j] = 1'b0;
                end
            end
        end
        // first table entry wins
        sel = 0;
        for (int j = KW_TABLE_SIZE - 1; j >= 0; j--) begin
            if (hit[j]) begin
                sel = j;
            end
        end
        sel_len = kw_len(sel);
        sel_cls = kw_cls(sel);

        if (w_emit && (n_ahead == '0)) begin
            if (!r_syn) begin
                n_lab[0] = CLS_NORMAL; n_prev = CLS_NORMAL; n_ahead = CW'(1);
            end else if (n_q == Q_NONE && !n_blk && b0 == "/" && b1 == "/") begin
                for (int j = 0; j < LOOKAHEAD; j++) begin
                    if (CW'(j) < n_fill) begin
                        n_lab[j] = CLS_LINE_COMMENT;
                    end
                end
                n_ahead = n_fill;
                n_prev  = CLS_LINE_COMMENT;
                n_rest  = 1'b1;
            end else if (n_q == Q_NONE && n_blk) begin
                n_lab[0] = CLS_BLOCK_COMMENT; n_prev = CLS_BLOCK_COMMENT;
                n_ahead = CW'(1);
                if (b0 == "*" && b1 == "/") begin
                    n_lab[1] = CLS_BLOCK_COMMENT; n_ahead = CW'(2);
                    n_blk = 1'b0; n_sep = 1'b1;
                end
            end else if (n_q == Q_NONE && b0 == "/" && b1 == "*") begin
                n_lab[0] = CLS_BLOCK_COMMENT; n_lab[1] = CLS_BLOCK_COMMENT;
                n_prev = CLS_BLOCK_COMMENT; n_ahead = CW'(2); n_blk = 1'b1;
            end else if (r_str && n_q != Q_NONE) begin
                n_lab[0] = CLS_STRING; n_prev = CLS_STRING; n_ahead = CW'(1);
                if (n_esc) begin
                    n_esc = 1'b0;
                end else if (b0 == "\\" && !w_last) begin
                    n_esc = 1'b1;
                end else begin
                    if ((n_q == Q_DOUBLE && b0 == "\"") || (n_q == Q_SINGLE && b0 == "'")) begin
                        n_q = Q_NONE;
                    end
                    n_sep = 1'b1;
                end
            end else if (r_str && (b0 == "\"" || b0 == "'")) begin
                n_q = (b0 == "\"") ? Q_DOUBLE : Q_SINGLE;
                n_lab[0] = CLS_STRING; n_prev = CLS_STRING; n_ahead = CW'(1);
            end else if (r_num && ((b0_dig && (n_sep || n_prev == CLS_NUMBER)) ||
                                   (b0 == "." && n_prev == CLS_NUMBER))) begin
                n_lab[0] = CLS_NUMBER; n_prev = CLS_NUMBER; n_ahead = CW'(1);
                n_sep = 1'b0;
            end else if (n_sep && (hit != '0)) begin
                for (int t = 0; t < KW_MAX_LEN; t++) begin
                    if (t < sel_len && t < LOOKAHEAD) begin
                        n_lab[IW'(t)] = sel_cls;
                    end
                end
                n_prev  = sel_cls;
                n_ahead = CW'(sel_len);
                n_sep   = 1'b0;
            end else begin
                n_sep = is_sep(b0);
                n_lab[0] = CLS_NORMAL; n_prev = CLS_NORMAL; n_ahead = CW'(1);
            end
        end

        w_res.cls          = n_lab[0];
        w_res.line_last    = w_last;
        w_res.open_comment = w_last && n_blk;
        w_res.last_of_run  = r_flush ? w_last : 1'b1;

        if (w_emit) begin
            for (int k = 0; k < LOOKAHEAD - 1; k++) begin
                n_lab[k] = n_lab[k+1];
            end
            n_fill = n_fill - 1'b1;
            if (n_ahead != '0) begin
                n_ahead = n_ahead - 1'b1;
            end
        end
        n_flush = r_flush;
        if (w_accept && i_line_end) begin
            n_flush = 1'b1;
        end else if (w_emit && w_last) begin
            n_flush = 1'b0;
            n_q = Q_NONE; n_esc = 1'b0; n_sep = 1'b1; n_prev = CLS_NORMAL;
            n_rest = 1'b0; n_ahead = '0; n_fill = '0;
        end
    end

    // window payload; bytes shift with the labels
    always_ff @(posedge i_clk) begin
        r_lab <= n_lab;
        if (w_emit) begin
            for (int k = 0; k < LOOKAHEAD - 1; k++) begin
                r_win[k] <= a_win[k+1];
            end
            r_win[LOOKAHEAD-1] <= a_win[LOOKAHEAD-1];
        end else begin
            r_win <= a_win;
        end
        if (w_emit) begin
            r_fq[r_fhead ^ r_fcnt[0]] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_ahead <= '0;
            r_blk   <= 1'b0;
            r_q     <= Q_NONE;
            r_esc   <= 1'b0;
            r_sep   <= 1'b1;
            r_prev  <= CLS_NORMAL;
            r_rest  <= 1'b0;
            r_flush <= 1'b0;
            r_fhead <= 1'b0;
            r_fcnt  <= 2'd0;
            r_syn   <= 1'b1;
            r_num   <= 1'b1;
            r_str   <= 1'b1;
        end else begin
            r_fill  <= n_fill;
            r_ahead <= n_ahead;
            r_blk   <= n_blk;
            r_q     <= n_q;
            r_esc   <= n_esc;
            r_sep   <= n_sep;
            r_prev  <= n_prev;
            r_rest  <= n_rest;
            r_flush <= n_flush;
            if (w_pop) begin
                r_fhead <= ~r_fhead;
            end
            r_fcnt <= r_fcnt + {1'b0, w_emit} - {1'b0, w_pop};
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SYNTAX:  r_syn <= i_cfg_data;
                    CFG_NUMBERS: r_num <= i_cfg_data;
                    CFG_STRINGS: r_str <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    assign o_valid           = (r_fcnt != 2'd0);
    assign o_highlight_class = r_fq[r_fhead].cls;
    assign o_line_last       = r_fq[r_fhead].line_last;
    assign o_open_comment    = r_fq[r_fhead].open_comment;
    assign o_last_of_run     = r_fq[r_fhead].last_of_run;

endmodule
`default_nettype wire

[hdl/cshl_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module cshl_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [2:0] o_highlight_class,
    input wire logic       o_line_last,
    input wire logic       o_open_comment,
    input wire logic       o_last_of_run
);

    // a held result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_highlight_class))
        else $error("stalled result dropped or changed");

    // open comment flag only on a line's last byte
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_open_comment |-> o_line_last)
        else $error("open_comment without line_last");

    // end of a line always ends the flush run
    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_last |-> o_last_of_run)
        else $error("line_last without last_of_run");

    a_cls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_highlight_class != 3'd7)
        else $error("undefined highlight class");

endmodule

bind c_syntax_highlight_lexer cshl_checker u_cshl_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_highlight_class (o_highlight_class),
    .o_line_last       (o_line_last),
    .o_open_comment    (o_open_comment),
    .o_last_of_run     (o_last_of_run)
);
`default_nettype wire
